// File: design/srt_pkg.sv
// srt_pkg: shared types and constants for the sorted record table
// used by srt_ctrl, srt_datapath and sorted_record_table; no dependencies
package srt_pkg;

	localparam int DEPTH_DEFAULT = 16;
	localparam int KEY_W         = 32;
	localparam int PAY_W         = 32;
	localparam int POS_W         = 8;
	localparam int CNT_OUT_W     = 5;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_DELETE = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_POS   = 2'd3
	} stat_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_INIT,
		S_SCAN,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic  latch;
		logic  init;
		logic  step;
		logic  put_new;
		logic  cnt_inc;
		logic  cnt_dec;
		logic  grab;
		logic  out_load;
		stat_t res;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		op_t  op;
		logic full;
		logic bad_pos;
		logic stop_ins;
		logic match;
		logic drained;
	} dp_stat_t;

endpackage

// File: design/sorted_record_table.sv
// sorted_record_table: top level joining the sequencer and the datapath
// depends on srt_pkg, srt_ctrl, srt_datapath
//
// channel   direction  handshake            fields
// in        input      in_valid, in_stall   cmd, record_key, record_payload, position
// out       output     out_valid, out_stall status, found_key, found_payload, entry_count
//
// one command at a time; a scan reads the stored entries one after another, its pace
// set by the single read port of the record memories (one entry per cycle)
// full, bad position and unused commands skip the scan and go from the init state to the done state
// reset empties the table at once (count cleared, memories left as they are)
// a finished result waits in the output register while the next beat is taken;
// a stalled output holds the sequencer before it loads the next result
module sorted_record_table
	import srt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [1:0]              cmd,
	input  logic signed [KEY_W-1:0] record_key,
	input  logic [PAY_W-1:0]        record_payload,
	input  logic [POS_W-1:0]        position,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] found_key,
	output logic [PAY_W-1:0]        found_payload,
	output logic [CNT_OUT_W-1:0]    entry_count
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	srt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dp_stat   (dp_stat),
		.dp_cmd    (dp_cmd)
	);

	srt_datapath #(
		.DEPTH (DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.dp_cmd         (dp_cmd),
		.dp_stat        (dp_stat),
		.cmd            (cmd),
		.record_key     (record_key),
		.record_payload (record_payload),
		.position       (position),
		.status         (status),
		.found_key      (found_key),
		.found_payload  (found_payload),
		.entry_count    (entry_count)
	);

	// a result is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.out_load |-> !(out_valid && out_stall))
		else $error("result loaded over a stalled beat");

	// the new record is never written in a shifting cycle
	a_put_not_step: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.put_new |-> !dp_cmd.step)
		else $error("insert write collides with shift");

	// insert only grows the table below its depth
	a_inc_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.cnt_inc |-> !dp_stat.full)
		else $error("count raised on a full table");

	// an accepted beat keeps the input side busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while a beat is in progress");

endmodule

// File: design/srt_ctrl.sv
// srt_ctrl: command sequencer and output beat control for the sorted record table
// depends on srt_pkg
module srt_ctrl
	import srt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t dp_stat,
	output dp_cmd_t  dp_cmd
);

	state_t st_q, st_d;
	stat_t  res_q, res_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			res_q       <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			res_q <= res_d;
			if (dp_cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (st_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		st_d   = st_q;
		res_d  = res_q;
		dp_cmd = '0;
		dp_cmd.res = res_q;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					dp_cmd.latch = 1'b1;
					st_d = S_INIT;
				end
			end
			S_INIT: begin
				dp_cmd.init = 1'b1;
				case (dp_stat.op)
					OP_INSERT: begin
						if (dp_stat.full) begin
							res_d = ST_FULL;
							st_d  = S_DONE;
						end else begin
							st_d = S_SCAN;
						end
					end
					OP_SEARCH: st_d = S_SCAN;
					OP_DELETE: begin
						if (dp_stat.bad_pos) begin
							res_d = ST_BAD_POS;
							st_d  = S_DONE;
						end else begin
							st_d = S_SCAN;
						end
					end
					default: begin
						res_d = ST_BAD_POS;
						st_d  = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				case (dp_stat.op)
					OP_INSERT: begin
						if (dp_stat.stop_ins || dp_stat.drained) begin
							dp_cmd.put_new = 1'b1;
							dp_cmd.cnt_inc = 1'b1;
							res_d = ST_OK;
							st_d  = S_DONE;
						end else begin
							dp_cmd.step = 1'b1;
						end
					end
					OP_SEARCH: begin
						if (dp_stat.match) begin
							dp_cmd.grab = 1'b1;
							res_d = ST_OK;
							st_d  = S_DONE;
						end else if (dp_stat.drained) begin
							res_d = ST_NOT_FOUND;
							st_d  = S_DONE;
						end else begin
							dp_cmd.step = 1'b1;
						end
					end
					OP_DELETE: begin
						if (dp_stat.drained) begin
							dp_cmd.cnt_dec = 1'b1;
							res_d = ST_OK;
							st_d  = S_DONE;
						end else begin
							dp_cmd.step = 1'b1;
						end
					end
					default: begin
						res_d = ST_BAD_POS;
						st_d  = S_DONE;
					end
				endcase
			end
			S_DONE: begin
				if (!out_valid_q || !out_stall) begin
					dp_cmd.out_load = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

endmodule

// File: design/srt_datapath.sv
// srt_datapath: record memories, scan pointers, entry count and result registers
// depends on srt_pkg
module srt_datapath
	import srt_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 dp_cmd,
	output dp_stat_t                dp_stat,
	input  logic [1:0]              cmd,
	input  logic signed [KEY_W-1:0] record_key,
	input  logic [PAY_W-1:0]        record_payload,
	input  logic [POS_W-1:0]        position,
	output logic [1:0]              status,
	output logic signed [KEY_W-1:0] found_key,
	output logic [PAY_W-1:0]        found_payload,
	output logic [CNT_OUT_W-1:0]    entry_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int PW = CW + POS_W;

	logic signed [KEY_W-1:0] key_mem [DEPTH];
	logic [PAY_W-1:0]        pay_mem [DEPTH];

	op_t                     op_q;
	logic signed [KEY_W-1:0] key_q;
	logic [PAY_W-1:0]        pay_q;
	logic [POS_W-1:0]        pos_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           rd_ptr_q;
	logic [CW-1:0]           hole_q;
	logic                    pend_q;
	logic signed [KEY_W-1:0] key_rd_q;
	logic [PAY_W-1:0]        pay_rd_q;
	logic signed [KEY_W-1:0] fnd_key_q;
	logic [PAY_W-1:0]        fnd_pay_q;

	logic                    is_ins;
	logic                    rd_end;
	logic                    rd_go;
	logic [AW-1:0]           rd_addr;
	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [KEY_W-1:0] wr_key;
	logic [PAY_W-1:0]        wr_pay;
	logic                    shift;

	assign is_ins  = (op_q == OP_INSERT);
	assign rd_end  = is_ins ? (rd_ptr_q == '0) : (rd_ptr_q >= count_q);
	assign rd_go   = dp_cmd.step && !rd_end;
	assign rd_addr = is_ins ? AW'(rd_ptr_q - CW'(1)) : AW'(rd_ptr_q);
	assign shift   = dp_cmd.step && pend_q && (is_ins || op_q == OP_DELETE);
	assign wr_en   = shift || dp_cmd.put_new;
	assign wr_addr = AW'(hole_q);
	assign wr_key  = dp_cmd.put_new ? key_q : key_rd_q;
	assign wr_pay  = dp_cmd.put_new ? pay_q : pay_rd_q;

	assign dp_stat.op       = op_q;
	assign dp_stat.full     = (count_q >= CW'(DEPTH));
	assign dp_stat.bad_pos  = (PW'(pos_q) >= PW'(count_q));
	assign dp_stat.stop_ins = pend_q && (key_rd_q < key_q);
	assign dp_stat.match    = pend_q && (key_rd_q == key_q);
	assign dp_stat.drained  = !pend_q && rd_end;

	// record memories
	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			pay_mem[wr_addr] <= wr_pay;
		end
		if (rd_go) begin
			key_rd_q <= key_mem[rd_addr];
			pay_rd_q <= pay_mem[rd_addr];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= OP_INSERT;
			count_q  <= '0;
			rd_ptr_q <= '0;
			hole_q   <= '0;
			pend_q   <= 1'b0;
		end else begin
			if (dp_cmd.latch) begin
				op_q <= op_t'(cmd);
			end
			if (dp_cmd.cnt_inc) begin
				count_q <= count_q + CW'(1);
			end else if (dp_cmd.cnt_dec) begin
				count_q <= count_q - CW'(1);
			end
			pend_q <= rd_go;
			if (dp_cmd.init) begin
				case (op_q)
					OP_INSERT: begin
						rd_ptr_q <= count_q;
						hole_q   <= count_q;
					end
					OP_DELETE: begin
						rd_ptr_q <= CW'(pos_q) + CW'(1);
						hole_q   <= CW'(pos_q);
					end
					default: begin
						rd_ptr_q <= '0;
						hole_q   <= '0;
					end
				endcase
			end else begin
				if (rd_go) begin
					rd_ptr_q <= is_ins ? rd_ptr_q - CW'(1) : rd_ptr_q + CW'(1);
				end
				if (shift) begin
					hole_q <= is_ins ? hole_q - CW'(1) : hole_q + CW'(1);
				end
			end
		end
	end

	// beat capture and result registers
	always_ff @(posedge clk) begin
		if (dp_cmd.latch) begin
			key_q <= record_key;
			pay_q <= record_payload;
			pos_q <= position;
		end
		if (dp_cmd.init) begin
			fnd_key_q <= '0;
			fnd_pay_q <= '0;
		end else if (dp_cmd.grab) begin
			fnd_key_q <= key_rd_q;
			fnd_pay_q <= pay_rd_q;
		end
		if (dp_cmd.out_load) begin
			status        <= dp_cmd.res;
			found_key     <= fnd_key_q;
			found_payload <= fnd_pay_q;
			entry_count   <= CNT_OUT_W'(count_q);
		end
	end

endmodule

// File: tb/sv/tb_sorted_record_table.sv
// tb_sorted_record_table: self-checking bench for the sorted record table, with its own
// table predictor, a queued beat driver, a result monitor and phased idling and stalling
// depends on srt_pkg and sorted_record_table
module tb_sorted_record_table;
	import srt_pkg::*;

	localparam int TBL_DEPTH = 16;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 40;
	localparam int BATCH_LEN = 65;

	typedef struct packed {
		op_t                     op;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
		logic [POS_W-1:0]        pos;
	} table_cmd_t;

	typedef struct packed {
		stat_t                   status;
		logic signed [KEY_W-1:0] key;
		logic [PAY_W-1:0]        payload;
		logic [CNT_OUT_W-1:0]    count;
	} table_reply_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [1:0]              cmd = OP_NONE;
	logic signed [KEY_W-1:0] record_key = '0;
	logic [PAY_W-1:0]        record_payload = '0;
	logic [POS_W-1:0]        position = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [1:0]              status;
	logic signed [KEY_W-1:0] found_key;
	logic [PAY_W-1:0]        found_payload;
	logic [CNT_OUT_W-1:0]    entry_count;

	// predictor state
	logic signed [KEY_W-1:0] shadow_key [TBL_DEPTH];
	logic [PAY_W-1:0]        shadow_pay [TBL_DEPTH];
	int                      shadow_count = 0;

	table_cmd_t   pending_cmds[$];
	table_reply_t awaited_replies[$];

	logic in_took = 1'b0;
	int   sender_idle_pct = 0;
	int   recv_stall_pct = 0;
	int   hold_requests = 0;
	int   hold_served = 0;
	int   hold_left = 0;
	int   fail_count = 0;
	int   replies_checked = 0;
	int   status_seen [4] = '{default: 0};
	int   search_hits = 0;
	int   full_reached = 0;

	sorted_record_table #(.DEPTH(TBL_DEPTH)) dut (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .record_key, .record_payload,
		.position, .out_valid, .out_stall, .status, .found_key, .found_payload,
		.entry_count
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic table_reply_t apply_to_table(input table_cmd_t c);
		table_reply_t r;
		int           slot;
		r = '{status: ST_OK, key: '0, payload: '0, count: '0};
		case (c.op)
			OP_INSERT: begin
				if (shadow_count >= TBL_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					slot = 0;
					while (slot < shadow_count && shadow_key[slot] < c.key)
						slot++;
					for (int i = shadow_count; i > slot; i--) begin
						shadow_key[i] = shadow_key[i-1];
						shadow_pay[i] = shadow_pay[i-1];
					end
					shadow_key[slot] = c.key;
					shadow_pay[slot] = c.payload;
					shadow_count++;
				end
			end
			OP_SEARCH: begin
				r.status = ST_NOT_FOUND;
				for (int i = 0; i < shadow_count; i++) begin
					if (shadow_key[i] == c.key) begin
						r.status = ST_OK;
						r.key = shadow_key[i];
						r.payload = shadow_pay[i];
						break;
					end
				end
			end
			OP_DELETE: begin
				if (int'(c.pos) >= shadow_count) begin
					r.status = ST_BAD_POS;
				end else begin
					for (int i = c.pos; i + 1 < shadow_count; i++) begin
						shadow_key[i] = shadow_key[i+1];
						shadow_pay[i] = shadow_pay[i+1];
					end
					shadow_count--;
				end
			end
			default: r.status = ST_BAD_POS;
		endcase
		r.count = CNT_OUT_W'(shadow_count);
		return r;
	endfunction

	function automatic logic signed [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0: return {1'b1, {(KEY_W-1){1'b0}}};
			1: return {1'b0, {(KEY_W-1){1'b1}}};
			2, 3, 4, 5: return $signed($urandom_range(0, 8)) - 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic table_cmd_t pick_cmd(input int ins_pct, input int del_pct);
		table_cmd_t c;
		int         r;
		r = $urandom_range(0, 99);
		c.key = pick_key();
		c.payload = $urandom;
		c.pos = ($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 255))
			: POS_W'($urandom_range(0, TBL_DEPTH + 1));
		if (r < ins_pct)
			c.op = OP_INSERT;
		else if (r < ins_pct + del_pct)
			c.op = OP_DELETE;
		else if (r < 97)
			c.op = OP_SEARCH;
		else
			c.op = OP_NONE;
		return c;
	endfunction

	task automatic queue_cmd(input op_t op, input logic signed [KEY_W-1:0] key,
			input logic [PAY_W-1:0] pay, input logic [POS_W-1:0] pos);
		pending_cmds.push_back('{op: op, key: key, payload: pay, pos: pos});
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || in_valid || awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// beat driver
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				cmd <= pending_cmds[0].op;
				record_key <= pending_cmds[0].key;
				record_payload <= pending_cmds[0].payload;
				position <= pending_cmds[0].pos;
				void'(pending_cmds.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stalls, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served <= hold_requests;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		table_reply_t want;
		if (!arst_n) begin
			in_took <= 1'b0;
		end else begin
			in_took <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				awaited_replies.push_back(apply_to_table('{op: op_t'(cmd), key: record_key,
					payload: record_payload, pos: position}));
				if (shadow_count == TBL_DEPTH)
					full_reached++;
			end
			if (out_valid && !out_stall) begin
				if (awaited_replies.size() == 0) begin
					$error("result beat with nothing expected: status %0d count %0d",
						status, entry_count);
					fail_count++;
				end else begin
					want = awaited_replies.pop_front();
					replies_checked++;
					status_seen[status]++;
					if (status == ST_OK && found_key == want.key && want.payload != 0)
						search_hits++;
					if (status !== want.status) begin
						$error("status: expected %0d got %0d", want.status, status);
						fail_count++;
					end
					if (found_key !== want.key) begin
						$error("found_key: expected %0d got %0d", want.key, found_key);
						fail_count++;
					end
					if (found_payload !== want.payload) begin
						$error("found_payload: expected %h got %h", want.payload,
							found_payload);
						fail_count++;
					end
					if (entry_count !== want.count) begin
						$error("entry_count: expected %0d got %0d", want.count, entry_count);
						fail_count++;
					end
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int idle_set [4][2];
		int mix_set [4][2];
		idle_set = '{'{0, 0}, '{48, 0}, '{0, 48}, '{24, 24}};
		mix_set = '{'{70, 10}, '{25, 25}, '{10, 60}, '{40, 30}};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: empty table, unused code, extremes, equal keys, bad positions, full
		queue_cmd(OP_SEARCH, 0, 0, 0);
		queue_cmd(OP_DELETE, 0, 0, 0);
		queue_cmd(OP_NONE, -1, '1, '1);
		queue_cmd(OP_INSERT, {1'b0, {(KEY_W-1){1'b1}}}, 32'h0000_0000, 0);
		queue_cmd(OP_INSERT, {1'b1, {(KEY_W-1){1'b0}}}, 32'hffff_ffff, 0);
		queue_cmd(OP_INSERT, 0, 32'ha5a5_0001, 0);
		queue_cmd(OP_INSERT, 0, 32'h5a5a_0002, 0);
		queue_cmd(OP_SEARCH, 0, 0, 0);
		queue_cmd(OP_SEARCH, {1'b1, {(KEY_W-1){1'b0}}}, 0, 0);
		queue_cmd(OP_SEARCH, 7, 0, 0);
		queue_cmd(OP_DELETE, 0, 0, 8'd255);
		queue_cmd(OP_DELETE, 0, 0, 8'd4);
		queue_cmd(OP_DELETE, 0, 0, 8'd3);
		queue_cmd(OP_DELETE, 0, 0, 8'd0);
		for (int i = 0; i < TBL_DEPTH - 2; i++)
			queue_cmd(OP_INSERT, pick_key(), $urandom, 0);
		queue_cmd(OP_INSERT, 1, 32'h1234_5678, 0);
		queue_cmd(OP_SEARCH, {1'b0, {(KEY_W-1){1'b1}}}, 0, 0);
		wait_drained();

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = idle_set[p][0];
			recv_stall_pct = idle_set[p][1];
			for (int m = 0; m < 4; m++)
				for (int n = 0; n < BATCH_LEN; n++)
					pending_cmds.push_back(pick_cmd(mix_set[m][0], mix_set[m][1]));
			wait_drained();
		end

		// back-pressure: receiver holds off while the sender keeps offering beats
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		hold_requests++;
		for (int n = 0; n < 60; n++)
			pending_cmds.push_back(pick_cmd(50, 20));
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("checked %0d results: ok %0d, not found %0d, full %0d, bad position %0d",
			replies_checked, status_seen[ST_OK], status_seen[ST_NOT_FOUND],
			status_seen[ST_FULL], status_seen[ST_BAD_POS]);
		$display("table reached full %0d times, %0d search hits, %0d mismatches",
			full_reached, search_hits, fail_count);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
